// File: hdl/dq_pkg.sv
// dq_pkg: shared types and constants for the double-ended queue.
// Operation and status codes, sizes, and the word extension helper.
// No dependencies.
package dq_pkg;

	localparam int DEPTH      = 16;
	localparam int WORD_WIDTH = 32;
	localparam int FIELD_W    = 32;
	localparam int OCC_W      = 5;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [WORD_WIDTH-1:0] word_t;

	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_BACK  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_BACK   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef struct packed {
		logic  en;
		kind_t kind;
	} dq_ctl_t;

	function automatic logic signed [FIELD_W-1:0] dq_ext(input word_t w);
		return FIELD_W'(signed'(w));
	endfunction

endpackage

// File: hdl/double_ended_queue.sv
// double_ended_queue: bounded deque built as a row of dq_cell slots.
// Front is slot 0, back is the last valid slot. Uses dq_pkg, dq_cell.
//
// Usage:
//   Raise start with kind and value; the beat is taken at that edge when
//   busy is low. busy never rises, so one operation is taken every cycle.
//   kind: push front, push back, pop front, pop back.
//   In the cycle after a beat is taken, done pulses for one cycle with:
//     popped_value  word removed by a pop, else zero
//     status        ok, underflow (pop on empty), overflow (push on full)
//     front_value   front word after the operation, -1 when empty
//     back_value    back word after the operation, -1 when empty
//     occupancy     stored words after the operation
//   Throughput is one operation per cycle; every slot
//   updates from its neighbors in the same cycle, so no loop sets the rate.
//   A failed push or pop leaves the contents untouched.
//   Reset empties the queue at once and drops any pending result.
//   The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        kind,
	input  logic signed [dq_pkg::FIELD_W-1:0] value,
	output logic                              done,
	output logic signed [dq_pkg::FIELD_W-1:0] popped_value,
	output logic [1:0]                        status,
	output logic signed [dq_pkg::FIELD_W-1:0] front_value,
	output logic signed [dq_pkg::FIELD_W-1:0] back_value,
	output logic [dq_pkg::OCC_W-1:0]          occupancy
);
	import dq_pkg::*;

	word_t         cell_data  [DEPTH];
	logic          cell_valid [DEPTH];
	logic          cell_last  [DEPTH];
	dq_ctl_t       ctl;
	kind_t         op;
	word_t         push_word;
	word_t         back_word;
	logic          full;
	logic          empty;
	logic          is_push;
	logic          done_q;
	status_t       status_q;
	word_t         popped_q;
	logic [CNT_W-1:0] count_q;

	assign op        = kind_t'(kind);
	assign push_word = WORD_WIDTH'(value);
	assign full      = cell_valid[DEPTH-1];
	assign empty     = !cell_valid[0];
	assign is_push   = (op == KIND_PUSH_FRONT) || (op == KIND_PUSH_BACK);
	assign busy      = 1'b0;

	assign ctl.kind = op;
	assign ctl.en   = start && (is_push ? !full : !empty);

	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_last[i]) back_word = back_word | cell_data[i];
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		word_t l_data;
		logic  l_valid;
		word_t r_data;
		logic  r_valid;
		if (g == 0) begin : g_first
			assign l_data  = push_word;
			assign l_valid = 1'b1;
		end else begin : g_mid_l
			assign l_data  = cell_data[g-1];
			assign l_valid = cell_valid[g-1];
		end
		if (g == DEPTH - 1) begin : g_end
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_mid_r
			assign r_data  = cell_data[g+1];
			assign r_valid = cell_valid[g+1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.push_word  (push_word),
			.left_data  (l_data),
			.left_valid (l_valid),
			.right_data (r_data),
			.right_valid(r_valid),
			.data       (cell_data[g]),
			.valid      (cell_valid[g]),
			.last       (cell_last[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= ST_OK;
			count_q  <= '0;
		end else begin
			done_q <= start;
			if (start) begin
				if (ctl.en) status_q <= ST_OK;
				else status_q <= is_push ? ST_OVER : ST_UNDER;
			end
			if (ctl.en) begin
				if (is_push) count_q <= count_q + CNT_W'(1);
				else count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (ctl.en && op == KIND_POP_FRONT) popped_q <= cell_data[0];
			else if (ctl.en && op == KIND_POP_BACK) popped_q <= back_word;
			else popped_q <= '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = dq_ext(popped_q);
	assign front_value  = empty ? '1 : dq_ext(cell_data[0]);
	assign back_value   = empty ? '1 : dq_ext(back_word);
	assign occupancy    = OCC_W'(count_q);

endmodule

// File: hdl/dq_cell.sv
// dq_cell: one slot of the queue row; holds a word and its valid flag.
// Shifts toward either neighbor or takes the pushed word. Uses dq_pkg.
module dq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  dq_pkg::dq_ctl_t ctl,
	input  dq_pkg::word_t   push_word,
	input  dq_pkg::word_t   left_data,
	input  logic            left_valid,
	input  dq_pkg::word_t   right_data,
	input  logic            right_valid,
	output dq_pkg::word_t   data,
	output logic            valid,
	output logic            last
);
	import dq_pkg::*;

	word_t data_q;
	logic  valid_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			unique case (ctl.kind)
				KIND_PUSH_FRONT: data_q <= left_data;
				KIND_PUSH_BACK: begin
					if (!valid_q && left_valid) data_q <= push_word;
				end
				KIND_POP_FRONT: data_q <= right_data;
				KIND_POP_BACK: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.en) begin
			unique case (ctl.kind)
				KIND_PUSH_FRONT: valid_q <= left_valid;
				KIND_PUSH_BACK: begin
					if (left_valid) valid_q <= 1'b1;
				end
				KIND_POP_FRONT: valid_q <= right_valid;
				KIND_POP_BACK: begin
					if (!right_valid) valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign last  = valid_q && !right_valid;

endmodule
